// ===== hw/rtl/deque_with_value_removal_core_macros.svh =====
// Assertion macros shared by the deque RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DEQUE_WITH_VALUE_REMOVAL_CORE_MACROS_SVH
`define DEQUE_WITH_VALUE_REMOVAL_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQVR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DQVR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/dqvr_pkg.sv =====
// Shared types, constants and helpers for the deque core.
// No dependencies; used by the controller, the datapath and the top level.
package dqvr_pkg;

    // Store geometry.
    localparam int DEPTH = 16;
    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;

    // Stream widths.
    localparam int ACT_W       = 3;
    localparam int VAL_W       = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 32;
    localparam int STATUS_W    = 2;

    // Action codes.
    typedef enum logic [ACT_W-1:0] {
        ACT_INS_FRONT = 3'd0,
        ACT_INS_BACK  = 3'd1,
        ACT_REM_FRONT = 3'd2,
        ACT_REM_BACK  = 3'd3,
        ACT_REM_VALUE = 3'd4,
        ACT_LIST_FWD  = 3'd5,
        ACT_LIST_BWD  = 3'd6
    } t_action;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Read address selection, as offsets from the front.
    typedef enum logic [1:0] {
        RS_FWD      = 2'd0,
        RS_FWD_NEXT = 2'd1,
        RS_BACK     = 2'd2,
        RS_BWD      = 2'd3
    } t_rsel;

    // Write address selection.
    typedef enum logic [1:0] {
        WS_FRONT_M1 = 2'd0,
        WS_BACK     = 2'd1,
        WS_FWD      = 2'd2
    } t_wsel;

    // Result value selection.
    typedef enum logic [1:0] {
        VS_ZERO  = 2'd0,
        VS_INPUT = 2'd1,
        VS_READ  = 2'd2
    } t_vsel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        t_rsel   rsel;
        logic    we;
        t_wsel   wsel;
        logic    wdata_rd;
        logic    front_inc;
        logic    front_dec;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    idx_inc;
        logic    emit;
        t_status emit_status;
        t_vsel   emit_vsel;
        logic    emit_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             empty;
        logic             full;
        logic             match;
        logic             idx_last;
        logic             out_free;
    } t_sts;

    // Circular index: base plus an offset of at most DEPTH, modulo DEPTH.
    function automatic logic [IW-1:0] f_wrap(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[IW-1:0];
    endfunction

endpackage

// ===== hw/rtl/dqvr_dpath.sv =====
// Datapath of the deque core: entry store, front and count registers,
// walk index and result register. Depends on dqvr_pkg and the macro header.
`include "deque_with_value_removal_core_macros.svh"

module dqvr_dpath import dqvr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [ACT_W-1:0]    i_act,
    input  logic [VAL_W-1:0]    i_val,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_out_status,
    output logic [VAL_W-1:0]    o_out_value,
    output logic                o_out_last
);

    logic [VAL_W-1:0]    r_mem [DEPTH];
    logic [VAL_W-1:0]    r_rdata;
    logic [ACT_W-1:0]    r_act;
    logic [VAL_W-1:0]    r_val;
    logic [IW-1:0]       r_front;
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_idx;
    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [VAL_W-1:0]    r_o_value;
    logic                r_o_last;

    logic [CW-1:0]       idx_ext;
    logic [CW-1:0]       roff;
    logic [IW-1:0]       raddr;
    logic [IW-1:0]       waddr;
    logic [VAL_W-1:0]    wdata;
    logic [IW-1:0]       front_m1;
    logic [IW-1:0]       front_p1;
    logic [VAL_W-1:0]    emit_value;
    logic                out_free;

    assign idx_ext  = CW'(r_idx);
    assign front_m1 = f_wrap(r_front, CW'(DEPTH - 1));
    assign front_p1 = f_wrap(r_front, CW'(1));
    assign out_free = !r_o_valid || i_out_ready;

    // Read offset from the front.
    always_comb begin
        case (i_cmd.rsel)
            RS_FWD:      roff = idx_ext;
            RS_FWD_NEXT: roff = idx_ext + CW'(1);
            RS_BACK:     roff = r_count - CW'(1);
            RS_BWD:      roff = r_count - CW'(1) - idx_ext;
            default:     roff = idx_ext;
        endcase
    end

    assign raddr = f_wrap(r_front, roff);

    // Write address and data.
    always_comb begin
        case (i_cmd.wsel)
            WS_FRONT_M1: waddr = front_m1;
            WS_BACK:     waddr = f_wrap(r_front, r_count);
            WS_FWD:      waddr = f_wrap(r_front, idx_ext);
            default:     waddr = f_wrap(r_front, idx_ext);
        endcase
    end

    assign wdata = i_cmd.wdata_rd ? r_rdata : r_val;

    // Entry store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_act;
            r_val <= i_val;
        end
    end

    // Front, count and walk index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.front_dec) begin
                r_front <= front_m1;
            end else if (i_cmd.front_inc) begin
                r_front <= front_p1;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
        end
    end

    // Result value selection.
    always_comb begin
        case (i_cmd.emit_vsel)
            VS_ZERO:  emit_value = '0;
            VS_INPUT: emit_value = r_val;
            VS_READ:  emit_value = r_rdata;
            default:  emit_value = '0;
        endcase
    end

    // Result register: holds one result while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status <= i_cmd.emit_status;
            r_o_value  <= emit_value;
            r_o_last   <= i_cmd.emit_last;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_status = r_o_status;
    assign o_out_value  = r_o_value;
    assign o_out_last   = r_o_last;

    // Status toward the controller.
    assign o_sts.act      = r_act;
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CW'(DEPTH));
    assign o_sts.match    = (r_rdata == r_val);
    assign o_sts.idx_last = ((idx_ext + CW'(1)) == r_count);
    assign o_sts.out_free = out_free;

    // A new result never overwrites one the receiver has not taken.
    `DQVR_ASSERT_NOW(a_emit_free, i_cmd.emit, !r_o_valid || i_out_ready, "result overwritten")
    // Inserts only happen with room in the store.
    `DQVR_ASSERT_NOW(a_ins_room, i_cmd.cnt_inc, r_count < CW'(DEPTH), "insert into full store")
    // Removals only happen on a non-empty store.
    `DQVR_ASSERT_NOW(a_rem_live, i_cmd.cnt_dec, r_count != '0, "removal from empty store")
    // An emitted result is presented in the following cycle.
    `DQVR_ASSERT_NEXT(a_emit_shown, i_cmd.emit, r_o_valid, "emitted result not presented")

endmodule

// ===== hw/rtl/dqvr_ctrl.sv =====
// Controller of the deque core: one-hot state machine that sequences the
// datapath for each request. Depends on dqvr_pkg.
module dqvr_ctrl import dqvr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_EXEC     = 10'b00_0000_0010,
        S_POP      = 10'b00_0000_0100,
        S_SCAN_RD  = 10'b00_0000_1000,
        S_SCAN_CHK = 10'b00_0001_0000,
        S_SH_RD    = 10'b00_0010_0000,
        S_SH_WR    = 10'b00_0100_0000,
        S_DONE     = 10'b00_1000_0000,
        S_LS_RD    = 10'b01_0000_0000,
        S_LS_EMIT  = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state         = r_state;
        cmd             = '0;
        cmd.rsel        = RS_FWD;
        cmd.wsel        = WS_FWD;
        cmd.emit_status = ST_OK;
        cmd.emit_vsel   = VS_ZERO;
        cmd.emit_last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_EXEC;
                end
            end

            S_EXEC: begin
                case (i_sts.act)
                    ACT_INS_FRONT, ACT_INS_BACK: begin
                        if (i_sts.out_free) begin
                            cmd.emit = 1'b1;
                            n_state  = S_IDLE;
                            if (i_sts.full) begin
                                cmd.emit_status = ST_FULL;
                            end else begin
                                cmd.we        = 1'b1;
                                cmd.wsel      = (i_sts.act == ACT_INS_FRONT) ?
                                                WS_FRONT_M1 : WS_BACK;
                                cmd.front_dec = (i_sts.act == ACT_INS_FRONT);
                                cmd.cnt_inc   = 1'b1;
                                cmd.emit_vsel = VS_INPUT;
                            end
                        end
                    end
                    ACT_REM_FRONT, ACT_REM_BACK, ACT_REM_VALUE,
                    ACT_LIST_FWD, ACT_LIST_BWD: begin
                        if (i_sts.empty) begin
                            if (i_sts.out_free) begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = ST_EMPTY;
                                n_state         = S_IDLE;
                            end
                        end else if (i_sts.act == ACT_REM_FRONT) begin
                            cmd.rsel = RS_FWD;
                            n_state  = S_POP;
                        end else if (i_sts.act == ACT_REM_BACK) begin
                            cmd.rsel = RS_BACK;
                            n_state  = S_POP;
                        end else if (i_sts.act == ACT_REM_VALUE) begin
                            n_state = S_SCAN_RD;
                        end else begin
                            n_state = S_LS_RD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            // Take the end entry once it has been read.
            S_POP: begin
                cmd.rsel = (i_sts.act == ACT_REM_FRONT) ? RS_FWD : RS_BACK;
                if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_vsel = VS_READ;
                    cmd.cnt_dec   = 1'b1;
                    cmd.front_inc = (i_sts.act == ACT_REM_FRONT);
                    n_state       = S_IDLE;
                end
            end

            // Search from the front for the first equal entry.
            S_SCAN_RD: begin
                cmd.rsel = RS_FWD;
                n_state  = S_SCAN_CHK;
            end

            S_SCAN_CHK: begin
                cmd.rsel = RS_FWD;
                if (i_sts.match) begin
                    n_state = S_SH_RD;
                end else if (i_sts.idx_last) begin
                    if (i_sts.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_NOT_FOUND;
                        n_state         = S_IDLE;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                    n_state     = S_SCAN_RD;
                end
            end

            // Close the gap: move each later entry one place forward.
            S_SH_RD: begin
                cmd.rsel = RS_FWD_NEXT;
                if (i_sts.idx_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SH_WR;
                end
            end

            S_SH_WR: begin
                cmd.we       = 1'b1;
                cmd.wsel     = WS_FWD;
                cmd.wdata_rd = 1'b1;
                cmd.idx_inc  = 1'b1;
                n_state      = S_SH_RD;
            end

            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_vsel = VS_INPUT;
                    cmd.cnt_dec   = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            // Listing: one read and one result per entry.
            S_LS_RD: begin
                cmd.rsel = (i_sts.act == ACT_LIST_FWD) ? RS_FWD : RS_BWD;
                n_state  = S_LS_EMIT;
            end

            S_LS_EMIT: begin
                cmd.rsel = (i_sts.act == ACT_LIST_FWD) ? RS_FWD : RS_BWD;
                if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_vsel = VS_READ;
                    cmd.emit_last = i_sts.idx_last;
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        n_state     = S_LS_RD;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

// ===== hw/rtl/deque_with_value_removal_core.sv =====
// Bounded double-ended queue of signed 32-bit values, 16 entries.
// Slave stream: one request per beat; tdata carries the action and a value.
// Master stream: results; tdata is the value, tuser the status, tlast marks
// the final result of a request. Every request except the undefined action
// gives at least one result.
// Steps per request: an insert, or a request on an empty or full store, is
// answered from the execute state; an end removal reads the end entry and
// then answers; a listing reads each entry and then emits it; a removal by
// value reads and compares each entry from the front, then moves each later
// entry forward with a read and a write, and answers; a missing value is
// answered after the last compare. The undefined action gives no result.
// The slave side is ready again as soon as the last result is loaded.
// One request is processed at a time; the controller walks the store through
// a single registered read port, which sets the pace of each request.
// The result register lets the next request be accepted while the last
// result still waits; when the receiver stalls, work that must emit waits.
// Reset empties the queue at once; entry contents are undefined until written.
// Depends on dqvr_pkg, dqvr_ctrl and dqvr_dpath.
module deque_with_value_removal_core import dqvr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: action [2:0], item_value [34:3], zero padding [39:35]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: result_value [31:0]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: status [1:0]
    output logic [STATUS_W-1:0]    m_axis_tuser,
    output logic                   m_axis_tlast
);

    t_cmd             cmd;
    t_sts             sts;
    logic [ACT_W-1:0] in_act;
    logic [VAL_W-1:0] in_val;

    // Unpack the request fields.
    assign in_act = s_axis_tdata[ACT_W-1:0];
    assign in_val = s_axis_tdata[ACT_W+VAL_W-1:ACT_W];

    dqvr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dqvr_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_act        (in_act),
        .i_val        (in_val),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_value  (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule

// ===== dv/deque_with_value_removal_core_tb.sv =====
// Self-checking testbench for the deque core: streams requests into the slave
// port and checks every result on the master port against an internal model.
// Depends on dqvr_pkg and the deque_with_value_removal_core RTL.
module deque_with_value_removal_core_tb;
    import dqvr_pkg::*;

    // One expected result beat.
    typedef struct packed {
        t_status          status;
        logic [VAL_W-1:0] value;
        logic             last;
    } t_deque_result;

    // Flavors of random request bursts.
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_ANY
    } t_burst_mix;

    localparam logic [ACT_W-1:0] ACT_UNDEFINED = 3'd7;
    localparam int RANDOM_REQS  = 270;
    localparam int IDLE_PCT     = 18;
    localparam int CALM_FIRST   = 120;
    localparam int CALM_LAST    = 190;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_REPORTS  = 10;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: action [2:0], item_value [34:3], zero padding [39:35]
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: result_value [31:0]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // tuser: status [1:0]
    logic [STATUS_W-1:0]    m_axis_tuser;
    logic                   m_axis_tlast;

    logic [IN_TDATA_W-1:0] pending_requests[$];
    t_deque_result         expected_results[$];
    int unsigned           accepted_cnt = 0;
    int unsigned           result_cnt   = 0;
    int unsigned           error_cnt    = 0;
    logic                  calm;

    // Contents the request planner assumes, used to aim value removals.
    logic [VAL_W-1:0] planned_contents[$];

    // Predicted deque state.
    logic [VAL_W-1:0] dq_store [DEPTH];
    int               dq_front = 0;
    int               dq_count = 0;

    deque_with_value_removal_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // No idling on either side for a stretch in the middle of the run.
    assign calm = (accepted_cnt >= CALM_FIRST) && (accepted_cnt < CALM_LAST);

    function automatic void count_failure(input string msg);
        error_cnt++;
        if (error_cnt <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void push_expected(input t_status st, input logic [VAL_W-1:0] val,
                                          input logic last);
        t_deque_result r;
        r.status = st;
        r.value  = val;
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    // Apply one accepted request to the predicted state and queue its results.
    function automatic void predict_deque_request(input logic [ACT_W-1:0] act,
                                                  input logic [VAL_W-1:0] val);
        int k;
        int off;
        case (act)
            ACT_INS_FRONT, ACT_INS_BACK: begin
                if (dq_count == DEPTH) begin
                    push_expected(ST_FULL, '0, 1'b1);
                end else begin
                    if (act == ACT_INS_FRONT) begin
                        dq_front = (dq_front + DEPTH - 1) % DEPTH;
                        dq_store[dq_front] = val;
                    end else begin
                        dq_store[(dq_front + dq_count) % DEPTH] = val;
                    end
                    dq_count++;
                    push_expected(ST_OK, val, 1'b1);
                end
            end
            ACT_REM_FRONT, ACT_REM_BACK: begin
                if (dq_count == 0) begin
                    push_expected(ST_EMPTY, '0, 1'b1);
                end else if (act == ACT_REM_FRONT) begin
                    push_expected(ST_OK, dq_store[dq_front], 1'b1);
                    dq_front = (dq_front + 1) % DEPTH;
                    dq_count--;
                end else begin
                    push_expected(ST_OK, dq_store[(dq_front + dq_count - 1) % DEPTH], 1'b1);
                    dq_count--;
                end
            end
            ACT_REM_VALUE: begin
                if (dq_count == 0) begin
                    push_expected(ST_EMPTY, '0, 1'b1);
                end else begin
                    k = 0;
                    while (k < dq_count && dq_store[(dq_front + k) % DEPTH] != val) begin
                        k++;
                    end
                    if (k == dq_count) begin
                        push_expected(ST_NOT_FOUND, '0, 1'b1);
                    end else begin
                        // Later entries slide one place toward the front.
                        for (; k + 1 < dq_count; k++) begin
                            dq_store[(dq_front + k) % DEPTH] =
                                dq_store[(dq_front + k + 1) % DEPTH];
                        end
                        dq_count--;
                        push_expected(ST_OK, val, 1'b1);
                    end
                end
            end
            ACT_LIST_FWD, ACT_LIST_BWD: begin
                if (dq_count == 0) begin
                    push_expected(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (k = 0; k < dq_count; k++) begin
                        off = (act == ACT_LIST_FWD) ? k : dq_count - 1 - k;
                        push_expected(ST_OK, dq_store[(dq_front + off) % DEPTH],
                                      k == dq_count - 1);
                    end
                end
            end
            default: begin
                // The undefined action is dropped without a result.
            end
        endcase
    endfunction

    // Queue a request and track what the store should hold afterwards.
    function automatic void plan_request(input logic [ACT_W-1:0] act,
                                         input logic [VAL_W-1:0] val);
        int k;
        pending_requests.push_back({{(IN_TDATA_W - ACT_W - VAL_W){1'b0}}, val, act});
        case (act)
            ACT_INS_FRONT: if (planned_contents.size() < DEPTH) planned_contents.push_front(val);
            ACT_INS_BACK:  if (planned_contents.size() < DEPTH) planned_contents.push_back(val);
            ACT_REM_FRONT: if (planned_contents.size() > 0) void'(planned_contents.pop_front());
            ACT_REM_BACK:  if (planned_contents.size() > 0) void'(planned_contents.pop_back());
            ACT_REM_VALUE: begin
                for (k = 0; k < planned_contents.size(); k++) begin
                    if (planned_contents[k] == val) begin
                        planned_contents.delete(k);
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Values: small ones so that duplicates occur, the extremes, or anything.
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0, 1, 2, 3: return VAL_W'($urandom_range(7));
            4: begin
                case ($urandom_range(3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Request driver: presents the next pending request when the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_requests.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PCT)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_requests.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: random back-pressure, result checks and request prediction.
    always @(posedge i_clk) begin : p_monitor
        t_deque_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

            // Compare each result with the oldest expectation.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    count_failure($sformatf(
                        "result %0d not expected: status %0d value %h last %0b",
                        result_cnt, m_axis_tuser, m_axis_tdata, m_axis_tlast));
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tuser !== want.status || m_axis_tdata !== want.value ||
                        m_axis_tlast !== want.last) begin
                        count_failure($sformatf({"result %0d mismatch: expected status %0d ",
                            "value %h last %0b, got status %0d value %h last %0b"},
                            result_cnt, want.status, want.value, want.last,
                            m_axis_tuser, m_axis_tdata, m_axis_tlast));
                    end
                end
                result_cnt <= result_cnt + 1;
            end

            // Every accepted request updates the predicted deque.
            if (s_axis_tvalid && s_axis_tready) begin
                predict_deque_request(s_axis_tdata[ACT_W-1:0], s_axis_tdata[ACT_W +: VAL_W]);
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    // Stimulus, reset and end of test.
    initial begin : p_sequence
        t_burst_mix       mix;
        int               burst_len;
        int               planned;
        int               roll;
        int               k;
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;

        // Directed: every removal and listing action on an empty store, and the undefined action.
        plan_request(ACT_REM_FRONT, 32'h1);
        plan_request(ACT_REM_BACK, 32'h2);
        plan_request(ACT_REM_VALUE, 32'h3);
        plan_request(ACT_LIST_FWD, 32'h4);
        plan_request(ACT_LIST_BWD, 32'h5);
        plan_request(ACT_UNDEFINED, 32'hdead_beef);
        // Extreme values at both ends, then listing in both directions.
        plan_request(ACT_INS_FRONT, 32'h7fff_ffff);
        plan_request(ACT_INS_BACK, 32'h8000_0000);
        plan_request(ACT_INS_FRONT, 32'hffff_ffff);
        plan_request(ACT_INS_BACK, 32'h0000_0000);
        plan_request(ACT_LIST_FWD, 32'h0);
        plan_request(ACT_LIST_BWD, 32'h0);
        // A missing value, then a removal from the middle that closes the gap.
        plan_request(ACT_REM_VALUE, 32'h1234_5678);
        plan_request(ACT_REM_VALUE, 32'h7fff_ffff);
        plan_request(ACT_REM_FRONT, 32'h0);
        plan_request(ACT_REM_BACK, 32'h0);
        // Fill the store, try two inserts too many and list it backward.
        for (k = 0; k < DEPTH; k++) begin
            plan_request((k % 2 == 0) ? ACT_INS_BACK : ACT_INS_FRONT, VAL_W'(k * 3 + 1));
        end
        plan_request(ACT_INS_BACK, 32'h5555_aaaa);
        plan_request(ACT_LIST_BWD, 32'h0);

        // Random bursts that grow, shrink or mix the contents.
        planned = 0;
        while (planned < RANDOM_REQS) begin
            mix       = t_burst_mix'($urandom_range(2));
            burst_len = $urandom_range(8, 30);
            for (k = 0; k < burst_len && planned < RANDOM_REQS; k++) begin
                roll = $urandom_range(99);
                if (mix == MIX_ANY) begin
                    roll = $urandom_range(1) ? roll : ((roll * 7) % 100);
                end
                if ((mix == MIX_GROW && roll < 70) || (mix == MIX_SHRINK && roll < 20) ||
                    (mix == MIX_ANY && roll < 30)) begin
                    act = $urandom_range(1) ? ACT_INS_BACK : ACT_INS_FRONT;
                end else if (roll < 82) begin
                    act = $urandom_range(1) ? ACT_REM_BACK : ACT_REM_FRONT;
                end else if (roll < 90) begin
                    act = ACT_REM_VALUE;
                end else if (roll < 98) begin
                    act = $urandom_range(1) ? ACT_LIST_BWD : ACT_LIST_FWD;
                end else begin
                    act = ACT_UNDEFINED;
                end
                val = pick_value();
                // Most value removals aim at an entry that is present.
                if (act == ACT_REM_VALUE && planned_contents.size() != 0 &&
                    $urandom_range(3) != 0) begin
                    val = planned_contents[$urandom_range(planned_contents.size() - 1)];
                end
                plan_request(act, val);
                if (act != ACT_UNDEFINED) begin
                    planned++;
                end
            end
        end

        // Hold synchronous reset, then release it.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all requests to go in and all results to come out.
        while (pending_requests.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #(20 * 400_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
